// ===== rtl/tbk_pkg.sv =====
// Shared constants, types and record layouts for the cascaded decade timer bank.
package tbk_pkg;

  // Bank geometry
  localparam int SLOTS_PER_UNIT = 8;
  localparam int UNIT_COUNT     = 4;
  localparam int TOTAL_SLOTS    = UNIT_COUNT * SLOTS_PER_UNIT;
  localparam int IDX_W          = $clog2(TOTAL_SLOTS);
  localparam int CNT_W          = $clog2(TOTAL_SLOTS + 1);

  // Field widths
  localparam int UNIT_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int TIMER_W = 16;
  localparam int DEC_W   = 4;
  localparam int FIRED_W = 32;

  // Decade stage carries when it sits at this value
  localparam logic [DEC_W-1:0] DECADE_LAST = 4'd9;

  // Request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // One slot record as held in the slot store
  typedef struct packed {
    logic               rep;
    logic [TIMER_W-1:0] period;
    logic [TIMER_W-1:0] remain;
  } slot_ent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_ent_t        wdata;
  } ram_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_rd_t;

  // Fields of a set transaction
  typedef struct packed {
    logic [UNIT_W-1:0]  unit;
    logic [SLOT_W-1:0]  slot;
    logic [TIMER_W-1:0] reload;
    logic               recurring;
  } set_req_t;

endpackage

// ===== rtl/tbk_slot_ram.sv =====
// Slot store: synchronous memory of slot records, registered read, per-entry valid bits.
module tbk_slot_ram (
  input  logic              clk,
  input  logic              rst,
  input  tbk_pkg::ram_wr_t  wr,
  input  tbk_pkg::ram_rd_t  rd,
  output tbk_pkg::slot_ent_t rdata
);
  import tbk_pkg::*;

  slot_ent_t              mem [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] valid;
  slot_ent_t              rd_q;
  logic                   rd_vld_q;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    if (rd.re) begin
      rd_q <= mem[rd.raddr];
    end
  end

  // Valid bits: an unwritten entry reads as an inactive slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.waddr] <= 1'b1;
      end
      if (rd.re) begin
        rd_vld_q <= valid[rd.raddr];
      end
    end
  end

  assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/tbk_cascade.sv =====
// Decade prescaler cascade and the four wrapping unit counters.
module tbk_cascade (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  output logic [tbk_pkg::UNIT_COUNT-1:0] tick_mask,
  output logic [tbk_pkg::TIMER_W-1:0] ms_count,
  output logic [tbk_pkg::TIMER_W-1:0] cs_count,
  output logic [tbk_pkg::TIMER_W-1:0] ds_count,
  output logic [tbk_pkg::TIMER_W-1:0] s_count
);
  import tbk_pkg::*;

  logic [DEC_W-1:0] ms_decade;
  logic [DEC_W-1:0] cs_decade;
  logic [DEC_W-1:0] ds_decade;

  // Units that tick on the next millisecond
  always_comb begin
    tick_mask[0] = 1'b1;
    tick_mask[1] = (ms_decade == DECADE_LAST);
    tick_mask[2] = tick_mask[1] && (cs_decade == DECADE_LAST);
    tick_mask[3] = tick_mask[2] && (ds_decade == DECADE_LAST);
  end

  // Stage update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_decade <= '0;
      cs_decade <= '0;
      ds_decade <= '0;
      ms_count  <= '0;
      cs_count  <= '0;
      ds_count  <= '0;
      s_count   <= '0;
    end else if (adv) begin
      ms_decade <= tick_mask[1] ? '0 : ms_decade + 4'd1;
      ms_count  <= ms_count + 16'd1;
      if (tick_mask[1]) begin
        cs_decade <= tick_mask[2] ? '0 : cs_decade + 4'd1;
        cs_count  <= cs_count + 16'd1;
      end
      if (tick_mask[2]) begin
        ds_decade <= tick_mask[3] ? '0 : ds_decade + 4'd1;
        ds_count  <= ds_count + 16'd1;
      end
      if (tick_mask[3]) begin
        s_count <= s_count + 16'd1;
      end
    end
  end

`ifndef SYNTH
  a_decade_range: assert property (@(posedge clk) disable iff (rst)
    ms_decade <= DECADE_LAST && cs_decade <= DECADE_LAST && ds_decade <= DECADE_LAST)
    else $error("decade stage out of range");

  a_ms_step: assert property (@(posedge clk) disable iff (rst)
    adv && !rst |=> ms_count == $past(ms_count) + 16'd1)
    else $error("ms counter did not step on tick");

  a_s_hold: assert property (@(posedge clk) disable iff (rst)
    !adv && !rst |=> $stable(s_count) && $stable(ds_count))
    else $error("counter moved without a tick");
`endif

endmodule

// ===== rtl/tbk_sweep.sv =====
// Sequencer: applies set transactions and walks the slots of each ticked unit.
module tbk_sweep (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go_tick,
  input  logic                           go_set,
  input  tbk_pkg::set_req_t              set_req,
  input  logic [tbk_pkg::UNIT_COUNT-1:0] tick_mask,
  output tbk_pkg::ram_rd_t               rd,
  input  tbk_pkg::slot_ent_t             rdata,
  output tbk_pkg::ram_wr_t               wr,
  output logic                           busy,
  output logic                           done,
  output logic [tbk_pkg::UNIT_COUNT-1:0] tick_units,
  output logic [tbk_pkg::FIRED_W-1:0]    fired
);
  import tbk_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] end_cnt;
  logic [CNT_W-1:0] end_cnt_next;
  logic             p_vld;
  logic [IDX_W-1:0] p_addr;

  logic               active;
  logic [TIMER_W-1:0] dec;
  logic               hit;
  logic [FIRED_W-1:0] hit_vec;
  logic               set_ok;
  logic [IDX_W-1:0]   set_idx;

  // Number of slots to walk: units tick as a prefix ms, cs, ds, s
  always_comb begin
    case (tick_mask)
      4'b1111: end_cnt_next = CNT_W'(4 * SLOTS_PER_UNIT);
      4'b0111: end_cnt_next = CNT_W'(3 * SLOTS_PER_UNIT);
      4'b0011: end_cnt_next = CNT_W'(2 * SLOTS_PER_UNIT);
      default: end_cnt_next = CNT_W'(SLOTS_PER_UNIT);
    endcase
  end

  // Slot update on the entry read back last cycle
  always_comb begin
    active  = (rdata.period != '0) && (rdata.remain != '0);
    dec     = rdata.remain - 16'd1;
    hit     = p_vld && active && (dec == '0);
    hit_vec = FIRED_W'(hit) << p_addr;
  end

  // Set transaction target
  always_comb begin
    set_ok  = (32'(set_req.slot) < SLOTS_PER_UNIT);
    set_idx = IDX_W'(32'(set_req.unit) * SLOTS_PER_UNIT + 32'(set_req.slot));
  end

  // Read port follows the walk pointer
  always_comb begin
    rd.re    = (state == S_WALK);
    rd.raddr = rd_ptr[IDX_W-1:0];
  end

  // Write port: walk write-back, else a set transaction
  always_comb begin
    wr = '0;
    if (p_vld && active) begin
      wr.we           = 1'b1;
      wr.waddr        = p_addr;
      wr.wdata.rep    = rdata.rep;
      wr.wdata.period = rdata.period;
      wr.wdata.remain = (dec == '0 && rdata.rep) ? rdata.period : dec;
    end else if (go_set && set_ok) begin
      wr.we           = 1'b1;
      wr.waddr        = set_idx;
      wr.wdata.rep    = set_req.recurring;
      wr.wdata.period = set_req.reload;
      wr.wdata.remain = set_req.reload;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequencer state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_ptr     <= '0;
      end_cnt    <= '0;
      p_vld      <= 1'b0;
      p_addr     <= '0;
      done       <= 1'b0;
      tick_units <= '0;
      fired      <= '0;
    end else begin
      done   <= 1'b0;
      p_vld  <= (state == S_WALK);
      p_addr <= rd_ptr[IDX_W-1:0];
      if (p_vld) begin
        fired <= fired | hit_vec;
      end
      case (state)
        S_IDLE: begin
          if (go_tick) begin
            tick_units <= tick_mask;
            fired      <= '0;
            end_cnt    <= end_cnt_next;
            rd_ptr     <= '0;
            state      <= S_WALK;
          end else if (go_set) begin
            tick_units <= '0;
            fired      <= '0;
            done       <= 1'b1;
          end
        end
        S_WALK: begin
          rd_ptr <= rd_ptr + 1'b1;
          if (rd_ptr == end_cnt - 1'b1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while sweep still running");

  a_set_no_fire: assert property (@(posedge clk) disable iff (rst)
    done && (tick_units == '0) |-> fired == '0)
    else $error("fired bits on a set transaction");

  a_busy_tick: assert property (@(posedge clk) disable iff (rst)
    busy |-> tick_units[0])
    else $error("sweep running without a millisecond tick");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    rd.re && wr.we |-> rd.raddr != wr.waddr)
    else $error("read and write to the same slot in one cycle");
`endif

endmodule

// ===== rtl/cascaded_decade_timer_bank_top.sv =====
// Top level of the cascaded decade timer bank: command port, prescaler, sequencer, slot store.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   command  | start / busy       | req_type, unit, slot, reload, recurring
//   result   | done (1-cycle)     | tick_units, fired, ms/cs/ds/s_total
//
// A set transaction writes the slot store in the accept cycle; its result
// strobes on the next cycle and busy never rises.
// A tick walks units*SLOTS_PER_UNIT slots (8, 16, 24 or 32) at one slot per
// cycle through the slot store's read-modify-write path; busy stays high through
// the walk and a drain state, and done strobes in the same cycle that busy falls.
// Reset is synchronous: slot valid bits, decades and counters clear at once.
// The receiver cannot stall: take each result in its done cycle; it holds until the next accept.
module cascaded_decade_timer_bank_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [tbk_pkg::UNIT_W-1:0]  unit,
  input  logic [tbk_pkg::SLOT_W-1:0]  slot,
  input  logic [tbk_pkg::TIMER_W-1:0] reload,
  input  logic                        recurring,
  output logic                        done,
  output logic [tbk_pkg::UNIT_COUNT-1:0] tick_units,
  output logic [tbk_pkg::FIRED_W-1:0] fired,
  output logic [tbk_pkg::TIMER_W-1:0] ms_total,
  output logic [tbk_pkg::TIMER_W-1:0] cs_total,
  output logic [tbk_pkg::TIMER_W-1:0] ds_total,
  output logic [tbk_pkg::TIMER_W-1:0] s_total
);
  import tbk_pkg::*;

  logic                  accept;
  logic                  go_tick;
  logic                  go_set;
  set_req_t              set_req;
  logic [UNIT_COUNT-1:0] tick_mask;
  ram_rd_t               rd;
  ram_wr_t               wr;
  slot_ent_t             rdata;

  // Command decode
  assign accept  = start && !busy;
  assign go_tick = accept && (req_type == REQ_TICK);
  assign go_set  = accept && (req_type == REQ_SET);

  always_comb begin
    set_req.unit      = unit;
    set_req.slot      = slot;
    set_req.reload    = reload;
    set_req.recurring = recurring;
  end

  tbk_cascade u_cascade (
    .clk       (clk),
    .rst       (rst),
    .adv       (go_tick),
    .tick_mask (tick_mask),
    .ms_count  (ms_total),
    .cs_count  (cs_total),
    .ds_count  (ds_total),
    .s_count   (s_total)
  );

  tbk_slot_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  tbk_sweep u_sweep (
    .clk        (clk),
    .rst        (rst),
    .go_tick    (go_tick),
    .go_set     (go_set),
    .set_req    (set_req),
    .tick_mask  (tick_mask),
    .rd         (rd),
    .rdata      (rdata),
    .wr         (wr),
    .busy       (busy),
    .done       (done),
    .tick_units (tick_units),
    .fired      (fired)
  );

endmodule
